[rtl/quicksort_lomuto_top_macros.svh]
// assertion macros shared by the checker of the sorting block
// depends on nothing; the including file supplies clock and reset signals
`ifndef QUICKSORT_LOMUTO_TOP_MACROS_SVH
`define QUICKSORT_LOMUTO_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define QSL_ASSERT_NOW(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define QSL_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

[rtl/qsl_pkg.sv]
// types, step labels and microcode table of the sorting block
// no dependencies; used by the sequencer and the top level
`timescale 1ns / 1ps

package qsl_pkg;

   localparam int VALUE_W       = 32;
   localparam int RANGE_FIELD_W = 6;
   localparam int RANGE_W       = 2 * RANGE_FIELD_W;
   localparam int PC_W          = 5;

   typedef logic [PC_W-1:0] pc_type;

   // program step labels
   localparam pc_type PC_IDLE  = 5'd0;
   localparam pc_type PC_INIT  = 5'd1;
   localparam pc_type PC_PUSH0 = 5'd2;
   localparam pc_type PC_POP   = 5'd3;
   localparam pc_type PC_LDR   = 5'd4;
   localparam pc_type PC_CHK   = 5'd5;
   localparam pc_type PC_KEY   = 5'd6;
   localparam pc_type PC_RDJ   = 5'd7;
   localparam pc_type PC_LOOP  = 5'd8;
   localparam pc_type PC_CMP   = 5'd9;
   localparam pc_type PC_SW1   = 5'd10;
   localparam pc_type PC_SW2   = 5'd11;
   localparam pc_type PC_NXJ   = 5'd12;
   localparam pc_type PC_FIN   = 5'd13;
   localparam pc_type PC_FIN2  = 5'd14;
   localparam pc_type PC_FIN3  = 5'd15;
   localparam pc_type PC_TR    = 5'd16;
   localparam pc_type PC_PR    = 5'd17;
   localparam pc_type PC_TL    = 5'd18;
   localparam pc_type PC_PL    = 5'd19;
   localparam pc_type PC_EINIT = 5'd20;
   localparam pc_type PC_ERD   = 5'd21;
   localparam pc_type PC_EWAIT = 5'd22;
   localparam pc_type PC_EHOLD = 5'd23;
   localparam pc_type PC_ENXT  = 5'd24;
   localparam pc_type PC_DONE  = 5'd25;

   typedef enum logic [3:0] {
      C_NEVER, C_ALWAYS, C_NOT_ACC_LAST, C_CNT_LT2, C_SP_ZERO, C_SKIP,
      C_J_EQ_HI, C_TMP_GT_KEY, C_NO_RIGHT, C_NO_LEFT, C_OUT_HELD, C_K_NOT_LAST
   } cond_type;

   typedef enum logic [1:0] {RS_HI, RS_J, RS_FILL, RS_K} rsel_type;

   typedef enum logic [2:0] {
      WR_NONE, WR_FILL_TMP, WR_J_TMP2, WR_FILL_KEY, WR_HI_TMP2
   } wr_type;

   typedef enum logic [2:0] {
      SK_NONE, SK_PUSH_ALL, SK_POP, SK_PUSH_RIGHT, SK_PUSH_LEFT
   } stk_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LD_RANGE, OP_INIT_SCAN, OP_LD_KEY, OP_LD_TMP, OP_LD_TMP2,
      OP_INC_FILL, OP_INC_J, OP_CLR_K, OP_LD_OUT, OP_INC_K, OP_CLR_RUN
   } op_type;

   // one control word
   typedef struct packed {
      cond_type cond;
      pc_type   target;
      logic     ready;
      rsel_type rd;
      wr_type   wr;
      stk_type  stk;
      op_type   op;
   } ctl_type;

   // datapath flags for the jump conditions
   typedef struct packed {
      logic acc_last;
      logic cnt_lt2;
      logic sp_zero;
      logic skip;
      logic j_eq_hi;
      logic tmp_gt_key;
      logic no_right;
      logic no_left;
      logic out_held;
      logic k_not_last;
   } stat_type;

   // microcode rom: next step is target when cond holds, else the following step
   function automatic ctl_type ucode_rom(input pc_type pc);
      ctl_type c;
      c.cond   = C_NEVER;
      c.target = PC_IDLE;
      c.ready  = 1'b0;
      c.rd     = RS_J;
      c.wr     = WR_NONE;
      c.stk    = SK_NONE;
      c.op     = OP_NONE;
      case (pc)
         PC_IDLE: begin
            c.ready = 1'b1; c.cond = C_NOT_ACC_LAST; c.target = PC_IDLE;
         end
         PC_INIT: begin
            c.cond = C_CNT_LT2; c.target = PC_EINIT;
         end
         PC_PUSH0: c.stk = SK_PUSH_ALL;
         PC_POP: begin
            c.stk = SK_POP; c.cond = C_SP_ZERO; c.target = PC_EINIT;
         end
         PC_LDR:  c.op = OP_LD_RANGE;
         PC_CHK: begin
            c.op = OP_INIT_SCAN; c.rd = RS_HI; c.cond = C_SKIP; c.target = PC_POP;
         end
         PC_KEY:  c.op = OP_LD_KEY;
         PC_RDJ:  c.rd = RS_J;
         PC_LOOP: begin
            c.op = OP_LD_TMP; c.rd = RS_FILL; c.cond = C_J_EQ_HI; c.target = PC_FIN;
         end
         PC_CMP: begin
            c.op = OP_LD_TMP2; c.cond = C_TMP_GT_KEY; c.target = PC_NXJ;
         end
         PC_SW1:  c.wr = WR_FILL_TMP;
         PC_SW2: begin
            c.wr = WR_J_TMP2; c.op = OP_INC_FILL;
         end
         PC_NXJ: begin
            c.op = OP_INC_J; c.cond = C_ALWAYS; c.target = PC_RDJ;
         end
         PC_FIN:  c.rd = RS_FILL;
         PC_FIN2: begin
            c.op = OP_LD_TMP2; c.wr = WR_FILL_KEY;
         end
         PC_FIN3: c.wr = WR_HI_TMP2;
         PC_TR: begin
            c.cond = C_NO_RIGHT; c.target = PC_TL;
         end
         PC_PR:   c.stk = SK_PUSH_RIGHT;
         PC_TL: begin
            c.cond = C_NO_LEFT; c.target = PC_POP;
         end
         PC_PL: begin
            c.stk = SK_PUSH_LEFT; c.cond = C_ALWAYS; c.target = PC_POP;
         end
         PC_EINIT: c.op = OP_CLR_K;
         PC_ERD:   c.rd = RS_K;
         PC_EWAIT: c.op = OP_LD_OUT;
         PC_EHOLD: begin
            c.cond = C_OUT_HELD; c.target = PC_EHOLD;
         end
         PC_ENXT: begin
            c.op = OP_INC_K; c.cond = C_K_NOT_LAST; c.target = PC_ERD;
         end
         PC_DONE: begin
            c.op = OP_CLR_RUN; c.cond = C_ALWAYS; c.target = PC_IDLE;
         end
         default: begin
            c.cond = C_ALWAYS; c.target = PC_IDLE;
         end
      endcase
      return c;
   endfunction

endpackage

[rtl/qsl_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module qsl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/qsl_useq.sv]
// microcode sequencer: step counter, control rom lookup, conditional jumps
// depends on qsl_pkg
`timescale 1ns / 1ps

module qsl_useq
   import qsl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output ctl_type  ctl
);

   pc_type pc_ff, pc_in;
   logic   take;

   assign ctl = ucode_rom(pc_ff);

   always_comb begin
      case (ctl.cond)
         C_NEVER:        take = 1'b0;
         C_ALWAYS:       take = 1'b1;
         C_NOT_ACC_LAST: take = ~stat.acc_last;
         C_CNT_LT2:      take = stat.cnt_lt2;
         C_SP_ZERO:      take = stat.sp_zero;
         C_SKIP:         take = stat.skip;
         C_J_EQ_HI:      take = stat.j_eq_hi;
         C_TMP_GT_KEY:   take = stat.tmp_gt_key;
         C_NO_RIGHT:     take = stat.no_right;
         C_NO_LEFT:      take = stat.no_left;
         C_OUT_HELD:     take = stat.out_held;
         C_K_NOT_LAST:   take = stat.k_not_last;
         default:        take = 1'b0;
      endcase
   end

   always_comb begin
      pc_in = take ? ctl.target : pc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

[rtl/quicksort_lomuto_top.sv]
// loading: a run of n values loads at one beat per cycle; sorting then pops each range,
// scans it comparing every value with the key and swapping those not greater, then
// places the key; each result is read from the store and held until rsp accepts it
// throughput: one run at a time; input is taken only while the sequencer is idle
// reset: synchronous, clears count, stack pointer, overflow flag, output valid, step
// counter; memories need no clearing pass
//
// top level of the sorting block: datapath, value store, range stack, sequencer
// depends on qsl_pkg, qsl_ram, qsl_useq
`timescale 1ns / 1ps

module quicksort_lomuto_top
   import qsl_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic               clock,
   input  logic               reset,
   // input channel
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [VALUE_W-1:0] req_tdata,   // [31:0] sample_value
   input  logic               req_tlast,   // last_flag
   // result channel
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [VALUE_W-1:0] rsp_tdata,   // [31:0] sorted_value
   output logic               rsp_tlast,   // last_out
   output logic               rsp_tuser    // [0] overflow_flag
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   ctl_type  ctl;
   stat_type stat;

   // control registers
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] sp_ff, sp_in;
   logic             ovf_ff, ovf_in;
   logic             out_valid_ff, out_valid_in;

   // scan indices and data holding registers
   logic [IDX_W-1:0]   lo_ff, lo_in, hi_ff, hi_in, j_ff, j_in, fill_ff, fill_in;
   logic [IDX_W-1:0]   k_ff, k_in;
   logic [VALUE_W-1:0] key_ff, key_in, tmp_ff, tmp_in, tmp2_ff, tmp2_in;
   logic [VALUE_W-1:0] out_value_ff, out_value_in;
   logic               out_last_ff, out_last_in, out_ovf_ff, out_ovf_in;

   // memory ports
   logic               st_we;
   logic [IDX_W-1:0]   st_waddr, st_raddr;
   logic [VALUE_W-1:0] st_wdata, st_rdata;
   logic               sk_we;
   logic [RANGE_W-1:0] sk_wdata, sk_rdata;
   logic [IDX_W-1:0]   sk_raddr;

   logic             req_acc, rsp_acc, room;
   logic [CNT_W-1:0] cnt_m1, sp_dec;
   logic             k_is_last;

   assign req_acc    = req_tvalid & req_tready;
   assign rsp_acc    = out_valid_ff & rsp_tready;
   assign room       = cnt_ff != CNT_W'(CAPACITY);
   assign cnt_m1     = cnt_ff - 1'b1;
   assign sp_dec     = sp_ff - 1'b1;
   assign k_is_last  = CNT_W'(k_ff) == cnt_m1;
   assign req_tready = ctl.ready;

   // condition flags for the sequencer
   always_comb begin
      stat.acc_last   = req_acc & req_tlast;
      stat.cnt_lt2    = cnt_ff < CNT_W'(2);
      stat.sp_zero    = sp_ff == '0;
      // a range of one value or none, or a range past the stored run
      stat.skip       = (lo_ff >= hi_ff) || (CNT_W'(hi_ff) >= cnt_ff);
      stat.j_eq_hi    = j_ff == hi_ff;
      stat.tmp_gt_key = $signed(tmp_ff) > $signed(key_ff);
      // right part pushed only if it holds two or more values
      stat.no_right   = !({1'b0, hi_ff} > ({1'b0, fill_ff} + 1'b1));
      stat.no_left    = !({1'b0, fill_ff} > ({1'b0, lo_ff} + 1'b1));
      stat.out_held   = out_valid_ff & ~rsp_tready;
      stat.k_not_last = ~k_is_last;
   end

   qsl_useq u_useq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   // value store: loading writes at the value count, swaps write through the microcode
   always_comb begin
      st_we    = 1'b0;
      st_waddr = fill_ff;
      st_wdata = tmp_ff;
      if (req_acc && room) begin
         st_we    = 1'b1;
         st_waddr = cnt_ff[IDX_W-1:0];
         st_wdata = req_tdata;
      end
      case (ctl.wr)
         WR_NONE: begin
         end
         WR_FILL_TMP: begin
            st_we = 1'b1; st_waddr = fill_ff; st_wdata = tmp_ff;
         end
         WR_J_TMP2: begin
            st_we = 1'b1; st_waddr = j_ff; st_wdata = tmp2_ff;
         end
         WR_FILL_KEY: begin
            st_we = 1'b1; st_waddr = fill_ff; st_wdata = key_ff;
         end
         WR_HI_TMP2: begin
            st_we = 1'b1; st_waddr = hi_ff; st_wdata = tmp2_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      case (ctl.rd)
         RS_HI:   st_raddr = hi_ff;
         RS_J:    st_raddr = j_ff;
         RS_FILL: st_raddr = fill_ff;
         RS_K:    st_raddr = k_ff;
         default: st_raddr = j_ff;
      endcase
   end

   qsl_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   // range stack: entries are begin in the upper field, end in the lower field
   always_comb begin
      sk_we    = 1'b0;
      sk_wdata = {RANGE_FIELD_W'(lo_ff), RANGE_FIELD_W'(hi_ff)};
      case (ctl.stk)
         SK_PUSH_ALL: begin
            sk_we = 1'b1; sk_wdata = {RANGE_FIELD_W'(0), RANGE_FIELD_W'(cnt_m1)};
         end
         SK_PUSH_RIGHT: begin
            sk_we    = 1'b1;
            sk_wdata = {RANGE_FIELD_W'(fill_ff + 1'b1), RANGE_FIELD_W'(hi_ff)};
         end
         SK_PUSH_LEFT: begin
            sk_we    = 1'b1;
            sk_wdata = {RANGE_FIELD_W'(lo_ff), RANGE_FIELD_W'(fill_ff - 1'b1)};
         end
         default: begin
         end
      endcase
   end

   // top of stack is read every cycle, so the popped entry shows up at the following step
   assign sk_raddr = sp_dec[IDX_W-1:0];

   qsl_ram #(
      .WIDTH (RANGE_W),
      .DEPTH (CAPACITY)
   ) u_stack (
      .clock   (clock),
      .wr_en   (sk_we),
      .wr_addr (sp_ff[IDX_W-1:0]),
      .wr_data (sk_wdata),
      .rd_addr (sk_raddr),
      .rd_data (sk_rdata)
   );

   // control register next values
   always_comb begin
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      sp_in        = sp_ff;
      out_valid_in = out_valid_ff;
      if (req_acc) begin
         if (room) begin
            cnt_in = cnt_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;   // store full: value dropped
         end
      end
      case (ctl.stk)
         SK_PUSH_ALL, SK_PUSH_RIGHT, SK_PUSH_LEFT: sp_in = sp_ff + 1'b1;
         SK_POP: begin
            if (sp_ff != '0) begin
               sp_in = sp_dec;
            end
         end
         default: begin
         end
      endcase
      if (rsp_acc) begin
         out_valid_in = 1'b0;
      end
      case (ctl.op)
         OP_LD_OUT: out_valid_in = 1'b1;
         OP_CLR_RUN: begin
            cnt_in = '0;
            sp_in  = '0;
            ovf_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // datapath register next values
   always_comb begin
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      j_in         = j_ff;
      fill_in      = fill_ff;
      k_in         = k_ff;
      key_in       = key_ff;
      tmp_in       = tmp_ff;
      tmp2_in      = tmp2_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;
      case (ctl.op)
         OP_LD_RANGE: begin
            lo_in = IDX_W'(sk_rdata[RANGE_W-1:RANGE_FIELD_W]);
            hi_in = IDX_W'(sk_rdata[RANGE_FIELD_W-1:0]);
         end
         OP_INIT_SCAN: begin
            j_in    = lo_ff;
            fill_in = lo_ff;
         end
         OP_LD_KEY:   key_in  = st_rdata;
         OP_LD_TMP:   tmp_in  = st_rdata;
         OP_LD_TMP2:  tmp2_in = st_rdata;
         OP_INC_FILL: fill_in = fill_ff + 1'b1;
         OP_INC_J:    j_in    = j_ff + 1'b1;
         OP_CLR_K:    k_in    = '0;
         OP_INC_K:    k_in    = k_ff + 1'b1;
         OP_LD_OUT: begin
            out_value_in = st_rdata;
            out_last_in  = k_is_last;
            out_ovf_in   = ovf_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         sp_ff        <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         sp_ff        <= sp_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      j_ff         <= j_in;
      fill_ff      <= fill_in;
      k_ff         <= k_in;
      key_ff       <= key_in;
      tmp_ff       <= tmp_in;
      tmp2_ff      <= tmp2_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
      out_ovf_ff   <= out_ovf_in;
   end

   // result beat register
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_value_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_ovf_ff;

endmodule

[rtl/qsl_checker.sv]
// port-level checker of the sorting block, bound to the top level
// depends on quicksort_lomuto_top_macros.svh and quicksort_lomuto_top
`timescale 1ns / 1ps
`include "quicksort_lomuto_top_macros.svh"

module qsl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   // a stalled result beat holds
   `QSL_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "stalled result beat changed")

   // no loading while a sorted run is being delivered
   `QSL_ASSERT_NOW(a_no_load_in_emit, rsp_tvalid, !req_tready, "input taken while results pending")

   // last input beat closes the load phase
   `QSL_ASSERT_NEXT(a_last_stops_load, req_tvalid && req_tready && req_tlast, !req_tready, "input still open after last beat")

   // nothing follows the last result beat
   `QSL_ASSERT_NEXT(a_run_end, rsp_tvalid && rsp_tready && rsp_tlast, !rsp_tvalid, "result beat after end of run")

endmodule

bind quicksort_lomuto_top qsl_checker u_qsl_checker (.*);

[tb/tb_quicksort_lomuto_top.sv]
// self-checking bench for the quicksort sorting block: streams signed runs in,
// predicts the sorted output with its own partition sort and checks every beat
// depends on qsl_pkg and quicksort_lomuto_top
`timescale 1ns / 1ps

module tb_quicksort_lomuto_top;

   localparam int CAPACITY    = 64;
   localparam int STALL_LIMIT = 100000;  // quiet limit, above the sorting time of a worst run of 64 equal values
   localparam int DRAIN_TAIL  = 200;
   localparam int CALM_TAIL   = 60;      // closing beats sent with no idling at all
   localparam int RUN_ITEMS   = 410;

   // one input beat as queued for the driver
   typedef struct {
      logic [31:0] value;
      logic        last;
      bit          drain;   // hold this beat back until all sorted output is in
   } sample_beat_type;

   // one predicted output beat
   typedef struct {
      logic [31:0] value;
      logic        last;
      logic        overflow;
   } sorted_beat_type;

   typedef enum {
      MIX_WIDE, MIX_NARROW, MIX_EDGES, MIX_RISING, MIX_FALLING
   } fill_style_type;

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [qsl_pkg::VALUE_W-1:0] req_tdata  = '0;   // [31:0] sample_value
   logic                        req_tlast  = 1'b0; // last_flag
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [qsl_pkg::VALUE_W-1:0] rsp_tdata;         // [31:0] sorted_value
   logic                        rsp_tlast;         // last_out
   logic                        rsp_tuser;         // [0] overflow_flag

   sample_beat_type sample_queue [$];
   sorted_beat_type sorted_due [$];

   // predictor state: the run being collected
   logic signed [31:0] run_store [CAPACITY];
   int                 run_count    = 0;
   bit                 run_overflow = 1'b0;

   int  fail_count   = 0;
   int  beats_in     = 0;
   int  calm_from    = 0;
   int  quiet_cycles = 0;
   int  send_gap     = 0;
   int  stall_left   = 0;
   bit  calm_run     = 1'b0;
   wire idle_ok      = !calm_run && (beats_in < calm_from);

   quicksort_lomuto_top #(
      .CAPACITY (CAPACITY)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // in-place quicksort of the collected run, last element of each range as pivot,
   // sub-ranges kept on an explicit stack instead of recursion
   function automatic void partition_sort();
      int                 lo_stack [$];
      int                 hi_stack [$];
      int                 lo;
      int                 hi;
      int                 fill;
      logic signed [31:0] key;
      logic signed [31:0] swap_tmp;
      if (run_count < 2) return;
      lo_stack.push_back(0);
      hi_stack.push_back(run_count - 1);
      while (lo_stack.size() > 0) begin
         lo   = lo_stack.pop_back();
         hi   = hi_stack.pop_back();
         key  = run_store[hi];
         fill = lo;
         // everything not greater than the pivot moves to the left part
         for (int j = lo; j < hi; j++) begin
            if (run_store[j] <= key) begin
               swap_tmp        = run_store[fill];
               run_store[fill] = run_store[j];
               run_store[j]    = swap_tmp;
               fill++;
            end
         end
         swap_tmp        = run_store[fill];
         run_store[fill] = run_store[hi];
         run_store[hi]   = swap_tmp;
         // only ranges of two or more values go back on the stack
         if (hi > fill + 1) begin
            lo_stack.push_back(fill + 1);
            hi_stack.push_back(hi);
         end
         if (fill > lo + 1) begin
            lo_stack.push_back(lo);
            hi_stack.push_back(fill - 1);
         end
      end
   endfunction

   // take one accepted input beat; a last beat sorts the run and queues its output
   function automatic void absorb_sample(logic [31:0] value, logic last);
      sorted_beat_type due;
      // a full store drops the value, even a last one, and marks the run
      if (run_count < CAPACITY) begin
         run_store[run_count] = value;
         run_count++;
      end else begin
         run_overflow = 1'b1;
      end
      if (!last) return;
      partition_sort();
      for (int k = 0; k < run_count; k++) begin
         due.value    = run_store[k];
         due.last     = (k == run_count - 1);
         due.overflow = run_overflow;
         sorted_due.push_back(due);
      end
      run_count    = 0;
      run_overflow = 1'b0;
   endfunction

   function automatic void queue_value(logic [31:0] value, logic last);
      sample_beat_type b;
      b.value = value;
      b.last  = last;
      b.drain = 1'b0;
      sample_queue.push_back(b);
   endfunction

   // one run of len beats, last flag on the final one
   function automatic void queue_run(int len, fill_style_type style, bit drain_first);
      logic [31:0]     base;
      sample_beat_type b;
      base = $urandom;
      for (int i = 0; i < len; i++) begin
         case (style)
            MIX_WIDE:    b.value = $urandom;
            MIX_NARROW:  b.value = $urandom_range(0, 8) - 4;   // lots of duplicates
            MIX_EDGES: begin
               case ($urandom_range(0, 4))
                  0:       b.value = 32'h8000_0000;
                  1:       b.value = 32'h7fff_ffff;
                  2:       b.value = 32'h0000_0000;
                  3:       b.value = 32'hffff_ffff;
                  default: b.value = 32'h0000_0001;
               endcase
            end
            MIX_RISING:  b.value = base + 32'(i * 3);
            default:     b.value = base - 32'(i * 3);
         endcase
         b.last  = (i == len - 1);
         b.drain = drain_first && (i == 0);
         sample_queue.push_back(b);
      end
   endfunction

   // driver: presents queued beats, holds them while stalled, inserts short gaps
   always @(posedge clock) begin : drive_samples
      bit              fire;
      bit              hold;
      sample_beat_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
         send_gap = 0;
      end else begin
         fire = req_tvalid && req_tready;
         hold = req_tvalid && !req_tready;
         if (fire) begin
            absorb_sample(req_tdata, req_tlast);
            beats_in <= beats_in + 1;
            // some runs go through with no idling on either side
            if (req_tlast) calm_run <= ($urandom_range(0, 3) == 0);
            if (idle_ok && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 3);
         end
         if (!hold) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (sample_queue.size() > 0 &&
                         !(sample_queue[0].drain && sorted_due.size() > 0)) begin
               nxt = sample_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.value;
               req_tlast  <= nxt.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each output beat against the oldest prediction, stalls at random
   always @(posedge clock) begin : check_results
      sorted_beat_type due;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (sorted_due.size() == 0) begin
               $error("unexpected output beat, sorted_value %0d", $signed(rsp_tdata));
               fail_count++;
            end else begin
               due = sorted_due.pop_front();
               if (rsp_tdata !== due.value) begin
                  $error("sorted_value: expected %0d, actual %0d",
                         $signed(due.value), $signed(rsp_tdata));
                  fail_count++;
               end
               if (rsp_tlast !== due.last) begin
                  $error("last_out: expected %0d, actual %0d", due.last, rsp_tlast);
                  fail_count++;
               end
               if (rsp_tuser !== due.overflow) begin
                  $error("overflow_flag: expected %0d, actual %0d", due.overflow, rsp_tuser);
                  fail_count++;
               end
            end
         end
         // stall bursts at random, only while idling is allowed
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_ok && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog: cycles since the last beat on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : run_test
      int             big;
      fill_style_type style;

      // single values at both extremes
      queue_value(32'h7fff_ffff, 1'b1);
      queue_value(32'h8000_0000, 1'b1);
      // extremes mixed with duplicates and values around zero
      queue_value(32'h7fff_ffff, 1'b0);
      queue_value(32'h8000_0000, 1'b0);
      queue_value(32'h0000_0000, 1'b0);
      queue_value(32'hffff_ffff, 1'b0);
      queue_value(32'h0000_0001, 1'b0);
      queue_value(32'h8000_0000, 1'b0);
      queue_value(32'h7fff_ffff, 1'b1);
      // already ascending, then descending
      for (int i = -3; i <= 1; i++) queue_value(32'(i), i == 1);
      for (int i = 4; i >= 0; i--) queue_value(32'(i * 10), i == 0);
      // all values equal, then a two-value swap
      for (int i = 0; i < 4; i++) queue_value(32'd7, i == 3);
      queue_value(32'd5, 1'b0);
      queue_value(-32'sd5, 1'b1);

      // full store without overflow (sender waits for all prior output first),
      // last beat dropped on a full store, then a longer overflowing run
      queue_run(CAPACITY, MIX_WIDE, 1'b1);
      queue_run(CAPACITY + 1, MIX_NARROW, 1'b0);
      queue_run(CAPACITY + 6, MIX_EDGES, 1'b0);

      // mostly short runs of mixed flavor, now and then a run near or past capacity
      while (sample_queue.size() < RUN_ITEMS) begin
         style = fill_style_type'($urandom_range(0, 4));
         big   = ($urandom_range(0, 14) == 0);
         queue_run(big ? $urandom_range(CAPACITY - 4, CAPACITY + 8) : $urandom_range(1, 12),
                   style, $urandom_range(0, 7) == 0);
      end
      calm_from = sample_queue.size() - CALM_TAIL;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // wait for every beat to go in and every prediction to come out
      while (!(sample_queue.size() == 0 && !req_tvalid && sorted_due.size() == 0) &&
             quiet_cycles < STALL_LIMIT)
         @(posedge clock);

      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILED: results differ");
      end else begin
         repeat (DRAIN_TAIL) @(posedge clock);
         if (fail_count == 0 && sorted_due.size() == 0)
            $display("PASSED: all results match");
         else
            $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
